>>> sv/vmu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vmu_pkg
// Operation codes shared by the vector math unit.
// ----------------------------------------------------------------------------
package vmu_pkg;

    typedef logic [2:0] t_mode;

    localparam t_mode MODE_ADD   = 3'd0;
    localparam t_mode MODE_SUB   = 3'd1;
    localparam t_mode MODE_SCALE = 3'd2;
    localparam t_mode MODE_DOT   = 3'd3;
    localparam t_mode MODE_CROSS = 3'd4;
    localparam t_mode MODE_LEN   = 3'd5;
    localparam t_mode MODE_NORM  = 3'd6;

endpackage
`default_nettype wire

>>> sv/vmu_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vmu_in_if / vmu_out_if
// Valid/ready channels of the vector math unit: operation items in,
// result items out.
// ----------------------------------------------------------------------------
interface vmu_in_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic [2:0]          mode;
    logic signed [W-1:0] ax;
    logic signed [W-1:0] ay;
    logic signed [W-1:0] az;
    logic signed [W-1:0] aw;
    logic signed [W-1:0] bx;
    logic signed [W-1:0] by;
    logic signed [W-1:0] bz;
    logic signed [W-1:0] bw;
    logic signed [W-1:0] scale_factor;

    modport source(output valid, mode, ax, ay, az, aw, bx, by, bz, bw, scale_factor,
                   input ready);
    modport sink(input valid, mode, ax, ay, az, aw, bx, by, bz, bw, scale_factor,
                 output ready);
endinterface

interface vmu_out_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] rx;
    logic signed [W-1:0] ry;
    logic signed [W-1:0] rz;
    logic signed [W-1:0] rw;
    logic signed [W-1:0] scalar_out;
    logic                saturated;

    modport source(output valid, rx, ry, rz, rw, scalar_out, saturated, input ready);
    modport sink(input valid, rx, ry, rz, rw, scalar_out, saturated, output ready);
endinterface
`default_nettype wire

>>> sv/vector_math_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vector_math_unit
// Four-component fixed-point vector ALU: add, subtract, scale, dot, cross,
// length and normalize, with rounding and saturation.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Carries
//  i_in     | in  | mode, vectors a and b, scale factor
//  o_out    | out | result vector, scalar, saturation flag
//
//  One item enters per cycle while i_in.ready is high; every item passes
//  through the square root (one root bit per stage) and the normalize
//  divider (one quotient bit per stage).
//  Reset clears only the valid bits. When the output item is not taken, the
//  whole pipeline holds and i_in.ready drops in the same cycle.
// ----------------------------------------------------------------------------
module vector_math_unit
    import vmu_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    vmu_in_if.sink    i_in,
    vmu_out_if.source o_out
);

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int XW = 2 * W + 3;     // wide signed intermediate
    localparam int SW = 2 * W + 1;     // sum of squares
    localparam int RB = W + 1;         // root bits
    localparam int SB = 2 * RB;        // padded radicand
    localparam int LW = RB + 1;        // rounded length
    localparam int DW = LW + 1;        // divisor 2L
    localparam int QB = F + 1;         // quotient bits

    localparam logic signed [XW-1:0] C_MAX  = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [XW-1:0] C_MIN  = ~C_MAX;
    localparam logic signed [XW-1:0] C_HALF = {{(XW-1){1'b0}}, 1'b1} << (F - 1);

    typedef struct packed {
        t_mode               mode;
        logic [3:0][W-1:0]   a;
        logic [3:0][W-1:0]   r;
        logic [W-1:0]        sc;
        logic                sat;
    } t_carry;

    // Returns {clamped flag, clamped word}.
    function automatic logic [W:0] f_clamp(input logic signed [XW-1:0] x);
        logic [W:0] res;
        if (x > C_MAX) begin
            res = {1'b1, C_MAX[W-1:0]};
        end else if (x < C_MIN) begin
            res = {1'b1, C_MIN[W-1:0]};
        end else begin
            res = {1'b0, x[W-1:0]};
        end
        return res;
    endfunction

    logic en;
    assign en = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    // ------------------------------------------------------------ stage 1
    logic signed [W-1:0]     in_a [4];
    logic signed [W-1:0]     in_b [4];
    logic signed [W-1:0]     op_x [6];
    logic signed [W-1:0]     op_y [6];
    logic signed [2*W-1:0]   n1_m [6];
    logic signed [W:0]       n1_as [4];

    logic                    r1_v;
    t_mode                   r1_mode;
    logic signed [W-1:0]     r1_a [4];
    logic signed [2*W-1:0]   r1_m [6];
    logic signed [W:0]       r1_as [4];

    always_comb begin
        in_a[0] = i_in.ax; in_a[1] = i_in.ay; in_a[2] = i_in.az; in_a[3] = i_in.aw;
        in_b[0] = i_in.bx; in_b[1] = i_in.by; in_b[2] = i_in.bz; in_b[3] = i_in.bw;
        for (int i = 0; i < 6; i++) begin
            op_x[i] = '0;
            op_y[i] = '0;
        end
        case (i_in.mode)
            MODE_SCALE: begin
                for (int i = 0; i < 4; i++) begin
                    op_x[i] = in_a[i];
                    op_y[i] = i_in.scale_factor;
                end
            end
            MODE_DOT: begin
                for (int i = 0; i < 4; i++) begin
                    op_x[i] = in_a[i];
                    op_y[i] = in_b[i];
                end
            end
            MODE_LEN, MODE_NORM: begin
                for (int i = 0; i < 4; i++) begin
                    op_x[i] = in_a[i];
                    op_y[i] = in_a[i];
                end
            end
            MODE_CROSS: begin
                op_x[0] = in_a[1]; op_y[0] = in_b[2];
                op_x[1] = in_a[2]; op_y[1] = in_b[1];
                op_x[2] = in_a[2]; op_y[2] = in_b[0];
                op_x[3] = in_a[0]; op_y[3] = in_b[2];
                op_x[4] = in_a[0]; op_y[4] = in_b[1];
                op_x[5] = in_a[1]; op_y[5] = in_b[0];
            end
            default: begin
            end
        endcase
        for (int i = 0; i < 6; i++) begin
            n1_m[i] = (2*W)'(op_x[i]) * (2*W)'(op_y[i]);
        end
        for (int i = 0; i < 4; i++) begin
            if (i_in.mode == MODE_SUB) begin
                n1_as[i] = (W+1)'(in_a[i]) - (W+1)'(in_b[i]);
            end else begin
                n1_as[i] = (W+1)'(in_a[i]) + (W+1)'(in_b[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_in.valid;
        end
        if (en) begin
            r1_mode <= i_in.mode;
            for (int i = 0; i < 4; i++) begin
                r1_a[i]  <= in_a[i];
                r1_as[i] <= n1_as[i];
            end
            for (int i = 0; i < 6; i++) begin
                r1_m[i] <= n1_m[i];
            end
        end
    end

    // ------------------------------------------------------------ stage 2
    logic signed [XW-1:0] n2_x [5];
    logic                 n2_rnd;
    logic [SW-1:0]        n2_sq;
    logic signed [XW-1:0] m_ext [6];
    logic signed [XW-1:0] m_sum;

    logic                 r2_v;
    t_mode                r2_mode;
    logic signed [W-1:0]  r2_a [4];
    logic signed [XW-1:0] r2_x [5];
    logic                 r2_rnd;
    logic [SW-1:0]        r2_sq;

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            m_ext[i] = XW'(r1_m[i]);
        end
        m_sum = m_ext[0] + m_ext[1] + m_ext[2] + m_ext[3];
        for (int i = 0; i < 5; i++) begin
            n2_x[i] = '0;
        end
        n2_rnd = 1'b1;
        n2_sq  = SW'(m_sum);
        case (r1_mode)
            MODE_ADD, MODE_SUB: begin
                n2_rnd = 1'b0;
                for (int i = 0; i < 4; i++) begin
                    n2_x[i] = XW'(r1_as[i]);
                end
            end
            MODE_SCALE: begin
                for (int i = 0; i < 4; i++) begin
                    n2_x[i] = m_ext[i];
                end
            end
            MODE_DOT: n2_x[4] = m_sum;
            MODE_CROSS: begin
                n2_x[0] = m_ext[0] - m_ext[1];
                n2_x[1] = m_ext[2] - m_ext[3];
                n2_x[2] = m_ext[4] - m_ext[5];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
        if (en) begin
            r2_mode <= r1_mode;
            r2_rnd  <= n2_rnd;
            r2_sq   <= n2_sq;
            for (int i = 0; i < 4; i++) begin
                r2_a[i] <= r1_a[i];
            end
            for (int i = 0; i < 5; i++) begin
                r2_x[i] <= n2_x[i];
            end
        end
    end

    // ------------------------------------------------------------ stage 3
    logic signed [XW-1:0] y3 [5];
    logic [W:0]           cl3 [5];
    t_carry               n3_c;

    logic                 r3_v;
    t_carry               r3_c;
    logic [SW-1:0]        r3_sq;

    always_comb begin
        n3_c.mode = r2_mode;
        n3_c.sat  = 1'b0;
        for (int i = 0; i < 5; i++) begin
            y3[i]  = r2_rnd ? ((r2_x[i] + C_HALF) >>> F) : r2_x[i];
            cl3[i] = f_clamp(y3[i]);
            n3_c.sat = n3_c.sat | cl3[i][W];
        end
        for (int i = 0; i < 4; i++) begin
            n3_c.a[i] = r2_a[i];
            n3_c.r[i] = cl3[i][W-1:0];
        end
        n3_c.sc = cl3[4][W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
        if (en) begin
            r3_c  <= n3_c;
            r3_sq <= r2_sq;
        end
    end

    // ------------------------------------------------------------ square root
    // One root bit per stage, restoring digit recurrence.
    logic           r_sq_v    [RB];
    t_carry         r_sq_c    [RB];
    logic [RB:0]    r_sq_rem  [RB];
    logic [RB-1:0]  r_sq_root [RB];
    logic [SB-1:0]  r_sq_rad  [RB];

    for (genvar j = 0; j < RB; j++) begin : g_sqrt
        logic           p_v;
        t_carry         p_c;
        logic [RB:0]    p_rem;
        logic [RB-1:0]  p_root;
        logic [SB-1:0]  p_rad;
        logic [RB+2:0]  t_rem;
        logic [RB+2:0]  t_try;

        if (j == 0) begin : g_first
            assign p_v    = r3_v;
            assign p_c    = r3_c;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_rad  = SB'(r3_sq);
        end else begin : g_next
            assign p_v    = r_sq_v[j-1];
            assign p_c    = r_sq_c[j-1];
            assign p_rem  = r_sq_rem[j-1];
            assign p_root = r_sq_root[j-1];
            assign p_rad  = r_sq_rad[j-1];
        end

        assign t_rem = {p_rem, p_rad[SB-1:SB-2]};
        assign t_try = {1'b0, p_root, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[j] <= 1'b0;
            end else if (en) begin
                r_sq_v[j] <= p_v;
            end
            if (en) begin
                r_sq_c[j]   <= p_c;
                r_sq_rad[j] <= {p_rad[SB-3:0], 2'b00};
                if (t_rem >= t_try) begin
                    r_sq_rem[j]  <= (RB+1)'(t_rem - t_try);
                    r_sq_root[j] <= {p_root[RB-2:0], 1'b1};
                end else begin
                    r_sq_rem[j]  <= (RB+1)'(t_rem);
                    r_sq_root[j] <= {p_root[RB-2:0], 1'b0};
                end
            end
        end
    end

    // ------------------------------------------------------------ stage 4
    // Rounded length, length result, and divider setup for normalize.
    logic [LW-1:0]   len4;
    logic [W:0]      cl4;
    logic [W-1:0]    mag4 [4];
    t_carry          n4_c;

    logic            r4_v;
    t_carry          r4_c;
    logic            r4_lz;
    logic [DW-1:0]   r4_d;
    logic [DW-1:0]   r4_rem [4];
    logic [QB-1:0]   r4_nq  [4];

    assign len4 = LW'(r_sq_root[RB-1])
                + LW'(r_sq_rem[RB-1] > (RB+1)'(r_sq_root[RB-1]));
    assign cl4  = f_clamp(XW'(len4));

    always_comb begin
        n4_c = r_sq_c[RB-1];
        if (n4_c.mode == MODE_LEN) begin
            n4_c.sc  = cl4[W-1:0];
            n4_c.sat = cl4[W];
        end
        for (int i = 0; i < 4; i++) begin
            mag4[i] = n4_c.a[i][W-1] ? (W)'(-n4_c.a[i]) : n4_c.a[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= r_sq_v[RB-1];
        end
        if (en) begin
            r4_c  <= n4_c;
            r4_lz <= (len4 == '0);
            r4_d  <= {len4, 1'b0};
            for (int i = 0; i < 4; i++) begin
                r4_rem[i] <= DW'(mag4[i]) + DW'(len4 >> QB);
                r4_nq[i]  <= QB'(len4);
            end
        end
    end

    // ------------------------------------------------------------ divider
    // Each stage brings down one numerator bit and retires one quotient bit
    // in the low end of the same shift register.
    logic           r_dv_v   [QB];
    t_carry         r_dv_c   [QB];
    logic           r_dv_lz  [QB];
    logic [DW-1:0]  r_dv_d   [QB];
    logic [DW-1:0]  r_dv_rem [QB][4];
    logic [QB-1:0]  r_dv_nq  [QB][4];

    for (genvar k = 0; k < QB; k++) begin : g_div
        logic           p_v;
        t_carry         p_c;
        logic           p_lz;
        logic [DW-1:0]  p_d;
        logic [DW-1:0]  p_rem [4];
        logic [QB-1:0]  p_nq  [4];

        if (k == 0) begin : g_first
            assign p_v  = r4_v;
            assign p_c  = r4_c;
            assign p_lz = r4_lz;
            assign p_d  = r4_d;
            for (genvar i = 0; i < 4; i++) begin : g_lane
                assign p_rem[i] = r4_rem[i];
                assign p_nq[i]  = r4_nq[i];
            end
        end else begin : g_next
            assign p_v  = r_dv_v[k-1];
            assign p_c  = r_dv_c[k-1];
            assign p_lz = r_dv_lz[k-1];
            assign p_d  = r_dv_d[k-1];
            for (genvar i = 0; i < 4; i++) begin : g_lane
                assign p_rem[i] = r_dv_rem[k-1][i];
                assign p_nq[i]  = r_dv_nq[k-1][i];
            end
        end

        for (genvar i = 0; i < 4; i++) begin : g_step
            logic [DW:0] t_rem;
            logic        q_bit;
            assign t_rem = {p_rem[i], p_nq[i][QB-1]};
            assign q_bit = (t_rem >= {1'b0, p_d});

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dv_rem[k][i] <= q_bit ? DW'(t_rem - {1'b0, p_d}) : DW'(t_rem);
                    r_dv_nq[k][i]  <= {p_nq[i][QB-2:0], q_bit};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k] <= 1'b0;
            end else if (en) begin
                r_dv_v[k] <= p_v;
            end
            if (en) begin
                r_dv_c[k]  <= p_c;
                r_dv_lz[k] <= p_lz;
                r_dv_d[k]  <= p_d;
            end
        end
    end

    // ------------------------------------------------------------ output
    t_carry               last_c;
    t_carry               n_o_c;
    logic signed [XW-1:0] qv   [4];
    logic [W:0]           clq  [4];

    logic                 r_o_v;
    t_carry               r_o_c;

    assign last_c = r_dv_c[QB-1];

    always_comb begin
        n_o_c = last_c;
        for (int i = 0; i < 4; i++) begin
            qv[i]  = last_c.a[i][W-1] ? -XW'(r_dv_nq[QB-1][i]) : XW'(r_dv_nq[QB-1][i]);
            clq[i] = f_clamp(qv[i]);
        end
        if (last_c.mode == MODE_NORM && !r_dv_lz[QB-1]) begin
            for (int i = 0; i < 4; i++) begin
                n_o_c.r[i] = clq[i][W-1:0];
                n_o_c.sat  = n_o_c.sat | clq[i][W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (en) begin
            r_o_v <= r_dv_v[QB-1];
        end
        if (en) begin
            r_o_c <= n_o_c;
        end
    end

    assign o_out.valid      = r_o_v;
    assign o_out.rx         = r_o_c.r[0];
    assign o_out.ry         = r_o_c.r[1];
    assign o_out.rz         = r_o_c.r[2];
    assign o_out.rw         = r_o_c.r[3];
    assign o_out.scalar_out = r_o_c.sc;
    assign o_out.saturated  = r_o_c.sat;

endmodule
`default_nettype wire

>>> tb/vector_math_unit_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_math_unit_tb_if
// Handshake helper interface for the vector math unit bench: a free-running
// cycle count that drives the receiver's stall pattern.
// ----------------------------------------------------------------------------
interface vmu_tb_cycle_if (input logic i_clk);
    int unsigned count = 0;

    always @(posedge i_clk) begin
        count <= count + 1;
    end

    modport source(input i_clk, output count);
    modport sink(input i_clk, input count);
endinterface

>>> tb/vector_math_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_math_unit_test
// Self-checking bench for the fixed-point vector math unit: a directed table
// of corner cases, then random operation items under bursty input and
// output stalls, each result checked against its typed table result or a bit-exact Q16.16 predictor.
// ----------------------------------------------------------------------------
module vector_math_unit_test;
    import vmu_pkg::*;

    localparam int N_RANDOM = 1900;
    localparam int N_ROWS   = 22;
    localparam int SETTLE   = 80;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        t_mode              mode;
        logic signed [31:0] ax, ay, az, aw;
        logic signed [31:0] bx, by, bz, bw;
        logic signed [31:0] k;
    } vec_op_t;

    typedef struct packed {
        logic signed [31:0] rx, ry, rz, rw;
        logic signed [31:0] sc;
        logic               sat;
    } vec_res_t;

    typedef struct packed {
        logic    known;
        vec_op_t op;
        vec_res_t res;
    } vec_row_t;

    localparam logic signed [31:0] MAXW = 32'sh7fffffff;
    localparam logic signed [31:0] MINW = 32'sh80000000;
    localparam logic signed [31:0] ONE  = 32'sh00010000;
    localparam logic signed [31:0] NEG1 = 32'shffffffff;
    localparam wide_t WIDE_MAX = 128'sh7fffffff;
    localparam wide_t WIDE_MIN = -128'sh80000000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    vmu_in_if  #(.W(32)) in_ch();
    vmu_out_if #(.W(32)) out_ch();
    vmu_tb_cycle_if      cyc(.i_clk(i_clk));

    vector_math_unit #(
        .FRAC_BITS(16),
        .WORD_BITS(32)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Directed corner cases; rows without a typed result use the predictor.
    vec_row_t dir_rows [N_ROWS] = '{
        '{1'b1, '{MODE_ADD, MAXW, MAXW, MAXW, MAXW, 32'sd1, 32'sd1, 32'sd1, 32'sd1, 32'sd0},
              '{MAXW, MAXW, MAXW, MAXW, 32'sd0, 1'b1}},
        '{1'b1, '{MODE_ADD, MINW, MINW, MINW, MINW, NEG1, NEG1, NEG1, NEG1, MAXW},
              '{MINW, MINW, MINW, MINW, 32'sd0, 1'b1}},
        '{1'b1, '{MODE_SUB, MINW, MINW, MINW, MINW, 32'sd1, 32'sd1, 32'sd1, 32'sd1, MINW},
              '{MINW, MINW, MINW, MINW, 32'sd0, 1'b1}},
        '{1'b1, '{MODE_SUB, MAXW, MAXW, MAXW, MAXW, NEG1, NEG1, NEG1, NEG1, 32'sd0},
              '{MAXW, MAXW, MAXW, MAXW, 32'sd0, 1'b1}},
        '{1'b1, '{MODE_ADD, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
                  32'sd0}, '0},
        '{1'b1, '{MODE_SCALE, 32'sh10000, 32'sh20000, 32'sh30000, 32'sh40000,
                  MAXW, MINW, NEG1, 32'sd5, ONE},
              '{32'sh10000, 32'sh20000, 32'sh30000, 32'sh40000, 32'sd0, 1'b0}},
        '{1'b1, '{MODE_SCALE, MAXW, MAXW, MAXW, MAXW, 32'sd0, 32'sd0, 32'sd0, 32'sd0, MAXW},
              '{MAXW, MAXW, MAXW, MAXW, 32'sd0, 1'b1}},
        '{1'b1, '{MODE_SCALE, MINW, MINW, MINW, MINW, 32'sd0, 32'sd0, 32'sd0, 32'sd0, MINW},
              '{MAXW, MAXW, MAXW, MAXW, 32'sd0, 1'b1}},
        '{1'b1, '{MODE_DOT, ONE, 32'sd0, 32'sd0, 32'sd0, ONE, 32'sd0, 32'sd0, 32'sd0, MAXW},
              '{32'sd0, 32'sd0, 32'sd0, 32'sd0, ONE, 1'b0}},
        '{1'b1, '{MODE_DOT, MINW, MINW, MINW, MINW, MINW, MINW, MINW, MINW, 32'sd0},
              '{32'sd0, 32'sd0, 32'sd0, 32'sd0, MAXW, 1'b1}},
        '{1'b1, '{MODE_CROSS, ONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, ONE, 32'sd0, 32'sd0, 32'sd0},
              '{32'sd0, 32'sd0, ONE, 32'sd0, 32'sd0, 1'b0}},
        '{1'b0, '{MODE_CROSS, 32'sh12345, NEG1, MAXW, MAXW, MINW, 32'sh7777, NEG1, MAXW,
                  32'sd0}, '0},
        '{1'b0, '{MODE_CROSS, MINW, MAXW, MINW, 32'sd0, MAXW, MINW, MAXW, 32'sd0, 32'sd0}, '0},
        '{1'b1, '{MODE_LEN, 32'sh30000, 32'sh40000, 32'sd0, 32'sd0, MAXW, MAXW, MAXW, MAXW,
                  32'sd0}, '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sh50000, 1'b0}},
        '{1'b1, '{MODE_LEN, MINW, MINW, MINW, MINW, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
              '{32'sd0, 32'sd0, 32'sd0, 32'sd0, MAXW, 1'b1}},
        '{1'b0, '{MODE_LEN, 32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
                  32'sd0}, '0},
        '{1'b1, '{MODE_NORM, 32'sd0, 32'sd0, 32'sd0, 32'sd0, MAXW, MINW, NEG1, 32'sd1, MAXW},
              '0},
        '{1'b1, '{MODE_NORM, 32'sh30000, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
                  32'sd0, 32'sd0}, '{ONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0}},
        '{1'b1, '{MODE_NORM, 32'sd0, -32'sh20000, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
                  32'sd0, 32'sd0}, '{32'sd0, -ONE, 32'sd0, 32'sd0, 32'sd0, 1'b0}},
        '{1'b0, '{MODE_NORM, MINW, MINW, MAXW, MINW, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
              '0},
        '{1'b0, '{MODE_SCALE, 32'sh8000, NEG1, -32'sh8000, 32'sd1, 32'sd0, 32'sd0, 32'sd0,
                  32'sd0, 32'sh8000}, '0},
        '{1'b1, '{3'd7, MAXW, MINW, ONE, NEG1, MINW, MAXW, NEG1, ONE, MAXW}, '0}
    };

    vec_res_t    results_due [$];
    int unsigned fail_count = 0;

    function automatic logic signed [31:0] clamp_word(input wide_t x, inout logic sat);
        if (x < WIDE_MIN) begin
            sat = 1'b1;
            return MINW;
        end
        if (x > WIDE_MAX) begin
            sat = 1'b1;
            return MAXW;
        end
        return x[31:0];
    endfunction

    // Add one half, then drop the fraction bits; halves round up.
    function automatic logic signed [31:0] round_word(input wide_t x, inout logic sat);
        return clamp_word((x + wide_t'(32'sh8000)) >>> 16, sat);
    endfunction

    function automatic wide_t mul_wide(input logic signed [31:0] a, input logic signed [31:0] b);
        wide_t wa, wb;
        wa = a;
        wb = b;
        return wa * wb;
    endfunction

    // Floor square root by pairs of bits, then rounded to nearest.
    function automatic logic [127:0] root_nearest(input logic [127:0] s);
        logic [127:0] root, bitv, t;
        root = '0;
        bitv = 128'd1 << 126;
        while (bitv > s && bitv != 0) bitv = bitv >> 2;
        while (bitv != 0) begin
            t = root + bitv;
            if (s >= t) begin
                s = s - t;
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return (s > root) ? root + 1 : root;
    endfunction

    function automatic vec_res_t vector_result(input vec_op_t op);
        vec_res_t r;
        logic signed [31:0] a [4];
        logic signed [31:0] b [4];
        logic signed [31:0] v [4];
        wide_t acc, wa, wb;
        logic [127:0] len, mag, q;
        logic sat;
        sat = 1'b0;
        a = '{op.ax, op.ay, op.az, op.aw};
        b = '{op.bx, op.by, op.bz, op.bw};
        v = '{32'sd0, 32'sd0, 32'sd0, 32'sd0};
        r = '0;
        case (op.mode)
            MODE_ADD, MODE_SUB: begin
                for (int i = 0; i < 4; i++) begin
                    wa = a[i];
                    wb = b[i];
                    v[i] = clamp_word(op.mode == MODE_ADD ? wa + wb : wa - wb, sat);
                end
            end
            MODE_SCALE: begin
                for (int i = 0; i < 4; i++) v[i] = round_word(mul_wide(a[i], op.k), sat);
            end
            MODE_DOT: begin
                acc = '0;
                for (int i = 0; i < 4; i++) acc = acc + mul_wide(a[i], b[i]);
                r.sc = round_word(acc, sat);
            end
            MODE_CROSS: begin
                v[0] = round_word(mul_wide(a[1], b[2]) - mul_wide(a[2], b[1]), sat);
                v[1] = round_word(mul_wide(a[2], b[0]) - mul_wide(a[0], b[2]), sat);
                v[2] = round_word(mul_wide(a[0], b[1]) - mul_wide(a[1], b[0]), sat);
            end
            MODE_LEN, MODE_NORM: begin
                acc = '0;
                for (int i = 0; i < 4; i++) acc = acc + mul_wide(a[i], a[i]);
                len = root_nearest(acc);
                if (op.mode == MODE_LEN) begin
                    r.sc = clamp_word(len, sat);
                end else if (len != 0) begin
                    // Division rounded half away from zero, sign restored after.
                    for (int i = 0; i < 4; i++) begin
                        wa = a[i];
                        mag = (wa < 0) ? -wa : wa;
                        q = (mag * (128'd1 << 17) + len) / (len << 1);
                        wb = q;
                        v[i] = clamp_word(wa < 0 ? -wb : wb, sat);
                    end
                end
            end
            default: ;
        endcase
        r.rx = v[0];
        r.ry = v[1];
        r.rz = v[2];
        r.rw = v[3];
        r.sat = sat;
        return r;
    endfunction

    function automatic logic signed [31:0] random_word();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6: return $signed($urandom_range(0, 32'h60000)) - 32'sh30000;
            7: begin
                case ($urandom_range(0, 5))
                    0: return MAXW;
                    1: return MINW;
                    2: return 32'sd0;
                    3: return 32'sd1;
                    4: return NEG1;
                    default: return ONE;
                endcase
            end
            8: return $signed($urandom_range(0, 32'h2000000)) - 32'sh1000000;
            default: return $signed($urandom) >>> $urandom_range(1, 30);
        endcase
    endfunction

    function automatic vec_op_t random_op();
        vec_op_t op;
        op.mode = ($urandom_range(0, 15) == 0) ? 3'd7 : t_mode'($urandom_range(0, 6));
        op.ax = random_word();
        op.ay = random_word();
        op.az = random_word();
        op.aw = random_word();
        op.bx = random_word();
        op.by = random_word();
        op.bz = random_word();
        op.bw = random_word();
        op.k  = random_word();
        return op;
    endfunction

    // Hold the item on the channel until it is taken.
    task automatic send_op(input vec_op_t op);
        in_ch.valid        <= 1'b1;
        in_ch.mode         <= op.mode;
        in_ch.ax           <= op.ax;
        in_ch.ay           <= op.ay;
        in_ch.az           <= op.az;
        in_ch.aw           <= op.aw;
        in_ch.bx           <= op.bx;
        in_ch.by           <= op.by;
        in_ch.bz           <= op.bz;
        in_ch.bw           <= op.bw;
        in_ch.scale_factor <= op.k;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // Receiver: the stall pattern steps through four flavors, one of them with no stalls, as the cycle count advances.
    always @(posedge i_clk) begin
        case ((cyc.count / 300) % 4)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= ($urandom_range(0, 3) != 0);
            2: out_ch.ready <= (cyc.count[2:0] != 3'd0) && (cyc.count[4:3] != 2'd2);
            default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        vec_res_t got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.rx, out_ch.ry, out_ch.rz, out_ch.rw, out_ch.scalar_out,
                    out_ch.saturated};
            if (results_due.size() == 0) begin
                fail_count <= fail_count + 1;
                $display("%0t: unexpected result item %h", $time, got);
            end else begin
                want = results_due.pop_front();
                if (got !== want) begin
                    fail_count <= fail_count + 1;
                    $display("%0t: mismatch exp r=%h %h %h %h s=%h sat=%b", $time,
                             want.rx, want.ry, want.rz, want.rw, want.sc, want.sat);
                    $display("%0t:          got r=%h %h %h %h s=%h sat=%b", $time,
                             got.rx, got.ry, got.rz, got.rw, got.sc, got.sat);
                end
            end
        end
    end

    initial begin
        vec_op_t op;
        int      burst_left;
        int      wait_cycles;
        in_ch.valid        <= 1'b0;
        in_ch.mode         <= '0;
        in_ch.ax           <= '0;
        in_ch.ay           <= '0;
        in_ch.az           <= '0;
        in_ch.aw           <= '0;
        in_ch.bx           <= '0;
        in_ch.by           <= '0;
        in_ch.bz           <= '0;
        in_ch.bw           <= '0;
        in_ch.scale_factor <= '0;
        i_rst_n            <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        burst_left = $urandom_range(1, 8);
        for (int i = 0; i < N_ROWS + N_RANDOM; i++) begin
            if (i < N_ROWS) begin
                op = dir_rows[i].op;
                send_op(op);
                results_due.push_back(dir_rows[i].known ? dir_rows[i].res : vector_result(op));
            end else begin
                op = random_op();
                send_op(op);
                results_due.push_back(vector_result(op));
            end
            // Drain the pipeline once, between the table and the random items.
            if (i == N_ROWS - 1) begin
                in_ch.valid <= 1'b0;
                while (results_due.size() != 0) @(posedge i_clk);
            end else begin
                burst_left--;
                if (burst_left == 0) begin
                    in_ch.valid <= 1'b0;
                    repeat ($urandom_range(1, 9)) @(posedge i_clk);
                    burst_left = $urandom_range(1, 40);
                end
            end
        end
        in_ch.valid <= 1'b0;

        wait_cycles = 0;
        while (results_due.size() != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0 && results_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
